[hw/rtl/mvm_pkg.sv]
// Shared types, sizes and helpers for the matrix-vector multiply block.
// Depends on nothing; every RTL file refers to it by scoped names.
package mvm_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLS    = 64;
    localparam int VALUE_WIDTH = 16;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int RCNT_W  = 6;
    localparam int CCNT_W  = 7;
    localparam int SUM_W   = 32;
    localparam int ADDR_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W   = $clog2(MAX_COLS + 2);
    localparam int PROD_W  = 2 * VALUE_WIDTH;
    localparam int ACC_W   = PROD_W + ADDR_W + 1;
    localparam int DRAIN_LEN = MAX_ROWS + 6;
    localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    typedef struct packed {
        logic                           op;
        logic [ROW_W-1:0]               row_index;
        logic [COL_W-1:0]               col_index;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic                           vector_end;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]         result_row;
        logic signed [SUM_W-1:0]  product_sum;
        logic                     length_error;
        logic                     final_result;
    } t_result;

    // element travelling along the row of cells
    typedef struct packed {
        logic                           vld;
        logic                           first;
        logic [ADDR_W-1:0]              col;
        logic signed [VALUE_WIDTH-1:0]  x;
    } t_flow;

    typedef struct packed {
        logic                           en;
        logic [ADDR_W-1:0]              col;
        logic signed [VALUE_WIDTH-1:0]  value;
    } t_wr;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STREAM,
        ST_DRAIN,
        ST_OUTPUT,
        ST_ERR
    } t_state;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'($signed({1'b0, {(SUM_W-1){1'b1}}}));
        lo = ACC_W'($signed({1'b1, {(SUM_W-1){1'b0}}}));
        if (a > hi) begin
            return hi[SUM_W-1:0];
        end else if (a < lo) begin
            return lo[SUM_W-1:0];
        end
        return a[SUM_W-1:0];
    endfunction

endpackage

[hw/rtl/mvm_cell.sv]
// One row cell: local weight row memory, multiply-accumulate, result shift stage.
// Depends on mvm_pkg.
module mvm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mvm_pkg::t_wr                  i_wr,
    input  mvm_pkg::t_flow                i_flow,
    output mvm_pkg::t_flow                o_flow,
    input  mvm_pkg::t_cell_ctl            i_ctl,
    input  logic signed [mvm_pkg::SUM_W-1:0] i_sh,
    output logic signed [mvm_pkg::SUM_W-1:0] o_sh
);

    logic signed [mvm_pkg::VALUE_WIDTH-1:0] r_mem [mvm_pkg::MAX_COLS];
    logic signed [mvm_pkg::VALUE_WIDTH-1:0] r_w;
    mvm_pkg::t_flow                         r_flow;
    logic signed [mvm_pkg::PROD_W-1:0]      r_prod;
    logic                                   r_p_vld;
    logic                                   r_p_first;
    logic signed [mvm_pkg::ACC_W-1:0]       r_acc;
    logic signed [mvm_pkg::ACC_W-1:0]       n_acc;
    logic signed [mvm_pkg::SUM_W-1:0]       r_sh;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.col] <= i_wr.value;
        end
        r_w <= r_mem[i_flow.col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow.vld <= 1'b0;
            r_p_vld    <= 1'b0;
        end else begin
            r_flow.vld <= i_flow.vld;
            r_p_vld    <= r_flow.vld;
        end
        r_flow.first <= i_flow.first;
        r_flow.col   <= i_flow.col;
        r_flow.x     <= i_flow.x;
        r_p_first    <= r_flow.first;
        r_prod       <= r_w * r_flow.x;
    end

    always_comb begin
        n_acc = r_acc;
        if (r_p_vld) begin
            n_acc = r_p_first ? mvm_pkg::ACC_W'(r_prod) : r_acc + mvm_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctl.load) begin
            r_sh <= mvm_pkg::sat_sum(r_acc);
        end else if (i_ctl.shift) begin
            r_sh <= i_sh;
        end
    end

    assign o_flow = r_flow;
    assign o_sh   = r_sh;

endmodule

[hw/rtl/matrix_vector_multiply.sv]
// Top level: command port, vector buffer, sequencer and the row of cells.
// Depends on mvm_pkg and mvm_cell.

// A matrix entry write or a vector element is taken on each accepted start,
// and the element marked last starts the multiply: the block is busy while
// it streams col_count elements and while the element stream passes down
// the row of cells, then presents row_count results (one when row_count is
// zero, MAX_ROWS when it is larger) on consecutive cycles, each for one
// cycle only with o_strobe high. The receiver cannot stall, so it must take
// every strobed result. A length mismatch gives one error result the cycle
// after the last element. Start is ignored while o_busy is high.
module matrix_vector_multiply (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  mvm_pkg::t_cmd        i_cmd,
    output logic                 o_strobe,
    output mvm_pkg::t_result     o_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [mvm_pkg::CCNT_W-1:0] i_cfg_data
);

    logic [mvm_pkg::RCNT_W-1:0] r_row_count;
    logic [mvm_pkg::CCNT_W-1:0] r_col_count;
    logic [mvm_pkg::CNT_W-1:0]  r_elem_cnt;
    logic [mvm_pkg::CNT_W-1:0]  n_elem_cnt;
    mvm_pkg::t_state            r_state;
    mvm_pkg::t_state            n_state;
    logic [mvm_pkg::CCNT_W-1:0] r_col;
    logic [mvm_pkg::DRAIN_W-1:0] r_wait;
    logic [mvm_pkg::RCNT_W-1:0] r_out_cnt;
    logic [mvm_pkg::RCNT_W-1:0] rows_last;
    logic                       accept;
    logic                       vec_acc;
    logic                       len_bad;
    logic                       stream_done;
    logic                       drain_done;
    logic                       out_done;

    logic signed [mvm_pkg::VALUE_WIDTH-1:0] r_vmem [mvm_pkg::MAX_COLS];
    logic signed [mvm_pkg::VALUE_WIDTH-1:0] r_vx;
    logic                                   r_iss_vld;
    logic                                   r_iss_first;
    logic [mvm_pkg::ADDR_W-1:0]             r_iss_col;

    mvm_pkg::t_flow     flow [mvm_pkg::MAX_ROWS+1];
    logic signed [mvm_pkg::SUM_W-1:0] sh [mvm_pkg::MAX_ROWS+1];
    mvm_pkg::t_cell_ctl ctl;

    assign accept  = i_start && !o_busy;
    assign vec_acc = accept && (i_cmd.op == mvm_pkg::OP_VECTOR);

    always_comb begin
        n_elem_cnt = r_elem_cnt;
        if (r_elem_cnt <= mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS)) begin
            n_elem_cnt = r_elem_cnt + 1'b1;
        end
    end

    assign len_bad = (mvm_pkg::CCNT_W'(n_elem_cnt) != r_col_count) || (r_col_count == '0)
                  || (r_col_count > mvm_pkg::CCNT_W'(mvm_pkg::MAX_COLS));

    always_comb begin
        if (r_row_count == '0) begin
            rows_last = '0;
        end else if (r_row_count > mvm_pkg::RCNT_W'(mvm_pkg::MAX_ROWS)) begin
            rows_last = mvm_pkg::RCNT_W'(mvm_pkg::MAX_ROWS - 1);
        end else begin
            rows_last = r_row_count - 1'b1;
        end
    end

    assign stream_done = (r_col == r_col_count - 1'b1);
    assign drain_done  = (r_wait == mvm_pkg::DRAIN_W'(mvm_pkg::DRAIN_LEN));
    assign out_done    = (r_out_cnt == rows_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= mvm_pkg::RCNT_W'(32);
            r_col_count <= mvm_pkg::CCNT_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvm_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[mvm_pkg::RCNT_W-1:0];
                mvm_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vector buffer: store while below capacity, saturate the count above it
    always_ff @(posedge i_clk) begin
        if (vec_acc && (r_elem_cnt < mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS))) begin
            r_vmem[r_elem_cnt[mvm_pkg::ADDR_W-1:0]] <= i_cmd.value;
        end
        r_vx <= r_vmem[r_col[mvm_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
        end else if (vec_acc) begin
            r_elem_cnt <= i_cmd.vector_end ? '0 : n_elem_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mvm_pkg::ST_IDLE: begin
                if (vec_acc && i_cmd.vector_end) begin
                    n_state = len_bad ? mvm_pkg::ST_ERR : mvm_pkg::ST_STREAM;
                end
            end
            mvm_pkg::ST_STREAM: if (stream_done) n_state = mvm_pkg::ST_DRAIN;
            mvm_pkg::ST_DRAIN:  if (drain_done)  n_state = mvm_pkg::ST_OUTPUT;
            mvm_pkg::ST_OUTPUT: if (out_done)    n_state = mvm_pkg::ST_IDLE;
            mvm_pkg::ST_ERR:    n_state = mvm_pkg::ST_IDLE;
            default:            n_state = mvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mvm_pkg::ST_IDLE;
            r_col     <= '0;
            r_wait    <= '0;
            r_out_cnt <= '0;
            r_iss_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iss_vld <= (r_state == mvm_pkg::ST_STREAM);
            r_col     <= (r_state == mvm_pkg::ST_STREAM) ? r_col + 1'b1 : '0;
            r_wait    <= (r_state == mvm_pkg::ST_DRAIN) ? r_wait + 1'b1 : '0;
            r_out_cnt <= (r_state == mvm_pkg::ST_OUTPUT) ? r_out_cnt + 1'b1 : '0;
        end
        r_iss_col   <= r_col[mvm_pkg::ADDR_W-1:0];
        r_iss_first <= (r_col == '0);
    end

    always_comb begin
        o_busy   = (r_state != mvm_pkg::ST_IDLE);
        o_strobe = 1'b0;
        o_result = '0;
        ctl.load  = (r_state == mvm_pkg::ST_DRAIN) && drain_done;
        ctl.shift = 1'b0;
        case (r_state)
            mvm_pkg::ST_OUTPUT: begin
                o_strobe              = 1'b1;
                o_result.result_row   = r_out_cnt[mvm_pkg::ROW_W-1:0];
                o_result.product_sum  = sh[0];
                o_result.final_result = out_done;
                ctl.shift             = 1'b1;
            end
            mvm_pkg::ST_ERR: begin
                o_strobe              = 1'b1;
                o_result.length_error = 1'b1;
                o_result.final_result = 1'b1;
            end
            default: ;
        endcase
    end

    assign flow[0].vld   = r_iss_vld;
    assign flow[0].first = r_iss_first;
    assign flow[0].col   = r_iss_col;
    assign flow[0].x     = r_vx;
    assign sh[mvm_pkg::MAX_ROWS] = '0;

    for (genvar k = 0; k < mvm_pkg::MAX_ROWS; k++) begin : g_cell
        mvm_pkg::t_wr wr;
        assign wr.en    = accept && (i_cmd.op == mvm_pkg::OP_WEIGHT)
                       && (32'(i_cmd.row_index) == k)
                       && (32'(i_cmd.col_index) < mvm_pkg::MAX_COLS);
        assign wr.col   = mvm_pkg::ADDR_W'(i_cmd.col_index);
        assign wr.value = i_cmd.value;

        mvm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_flow  (flow[k]),
            .o_flow  (flow[k+1]),
            .i_ctl   (ctl),
            .i_sh    (sh[k+1]),
            .o_sh    (sh[k])
        );
    end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for matrix_vector_multiply: a queue-fed command driver,
// a result monitor and a dot-product predictor kept in step with the block.
// Depends on mvm_pkg and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic                          o_busy;
    mvm_pkg::t_cmd                 i_cmd = '0;
    logic                          o_strobe;
    mvm_pkg::t_result              o_result;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_idx = mvm_pkg::CFG_ROW_COUNT;
    logic [mvm_pkg::CCNT_W-1:0]    i_cfg_data = '0;

    matrix_vector_multiply i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    mvm_pkg::t_cmd    cmd_queue[$];
    mvm_pkg::t_result expected_sums[$];
    int               fail_count = 0;
    int               sent_count = 0;

    // predictor state
    logic signed [mvm_pkg::VALUE_WIDTH-1:0] weights [mvm_pkg::MAX_ROWS][mvm_pkg::MAX_COLS];
    logic signed [mvm_pkg::VALUE_WIDTH-1:0] vec_buf [mvm_pkg::MAX_COLS];
    int unsigned elem_count = 0;
    logic [mvm_pkg::RCNT_W-1:0] rows_cfg = 6'd32;
    logic [mvm_pkg::CCNT_W-1:0] cols_cfg = 7'd64;

    // stimulus-side record of which weight entries hold a value
    bit written [mvm_pkg::MAX_ROWS][mvm_pkg::MAX_COLS];

    function automatic void predict_dot_products(input mvm_pkg::t_cmd c);
        int unsigned len;
        int unsigned nrows;
        longint acc;
        mvm_pkg::t_result r;
        if (c.op == mvm_pkg::OP_WEIGHT) begin
            weights[c.row_index][c.col_index] = c.value;
            return;
        end
        if (elem_count < mvm_pkg::MAX_COLS) vec_buf[elem_count] = c.value;
        if (elem_count <= mvm_pkg::MAX_COLS) elem_count++;
        if (!c.vector_end) return;
        len = elem_count;
        elem_count = 0;
        if (len != cols_cfg || cols_cfg == 0 || cols_cfg > mvm_pkg::MAX_COLS) begin
            r = '0;
            r.length_error = 1'b1;
            r.final_result = 1'b1;
            expected_sums = {expected_sums, r};
            return;
        end
        nrows = (rows_cfg == 0) ? 1 :
                (rows_cfg > mvm_pkg::MAX_ROWS) ? mvm_pkg::MAX_ROWS : rows_cfg;
        for (int i = 0; i < nrows; i++) begin
            acc = 0;
            for (int j = 0; j < cols_cfg; j++)
                acc += longint'(weights[i][j]) * longint'(vec_buf[j]);
            if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
            if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
            r.result_row   = i[mvm_pkg::ROW_W-1:0];
            r.product_sum  = acc[mvm_pkg::SUM_W-1:0];
            r.length_error = 1'b0;
            r.final_result = (i + 1 == nrows);
            expected_sums = {expected_sums, r};
        end
    endfunction

    // driver: take the transaction when accepted, then hold, advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && o_busy) begin
            i_start <= 1'b1;
        end else begin
            if (i_start) begin
                predict_dot_products(i_cmd);
                sent_count++;
            end
            if (cmd_queue.size() != 0 &&
                ((sent_count >= 90 && sent_count < 190) || $urandom_range(99) >= 6)) begin
                i_cmd   <= cmd_queue.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        mvm_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_sums.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: row %0d sum %0d err %b fin %b",
                             o_result.result_row, o_result.product_sum,
                             o_result.length_error, o_result.final_result);
            end else begin
                want = expected_sums.pop_front();
                if (o_result !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp row %0d sum %0d err %b fin %b, ",
                                  "got row %0d sum %0d err %b fin %b"},
                                 want.result_row, want.product_sum, want.length_error,
                                 want.final_result, o_result.result_row,
                                 o_result.product_sum, o_result.length_error,
                                 o_result.final_result);
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [mvm_pkg::CCNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == mvm_pkg::CFG_ROW_COUNT) rows_cfg = data[mvm_pkg::RCNT_W-1:0];
        else cols_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_start || o_busy || expected_sums.size() != 0);
        repeat (mvm_pkg::DRAIN_LEN + 20) @(posedge i_clk);
    endtask

    function automatic logic signed [mvm_pkg::VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return mvm_pkg::VALUE_WIDTH'($urandom());
        endcase
    endfunction

    function automatic void push_weight(input int r, input int c,
                                        input logic signed [mvm_pkg::VALUE_WIDTH-1:0] v);
        mvm_pkg::t_cmd cmd;
        cmd = $bits(mvm_pkg::t_cmd)'($urandom());
        cmd.op        = mvm_pkg::OP_WEIGHT;
        cmd.row_index = mvm_pkg::ROW_W'(r);
        cmd.col_index = mvm_pkg::COL_W'(c);
        cmd.value     = v;
        written[r][c] = 1'b1;
        cmd_queue = {cmd_queue, cmd};
    endfunction

    function automatic void push_vector(input int len, input bit fixed,
                                        input logic signed [mvm_pkg::VALUE_WIDTH-1:0] v);
        mvm_pkg::t_cmd cmd;
        for (int k = 0; k < len; k++) begin
            cmd = $bits(mvm_pkg::t_cmd)'($urandom());
            cmd.op         = mvm_pkg::OP_VECTOR;
            cmd.value      = fixed ? v : pick_value();
            cmd.vector_end = (k == len - 1);
            cmd_queue = {cmd_queue, cmd};
        end
    endfunction

    // make sure every weight in the region in use holds a value
    function automatic void fill_region(input int nrows, input int ncols);
        for (int r = 0; r < nrows; r++)
            for (int c = 0; c < ncols; c++)
                if (!written[r][c]) push_weight(r, c, pick_value());
    endfunction

    task automatic random_phase(input int nrows, input int ncols, input int n_items);
        int target;
        write_reg(mvm_pkg::CFG_ROW_COUNT, mvm_pkg::CCNT_W'(nrows));
        write_reg(mvm_pkg::CFG_COL_COUNT, mvm_pkg::CCNT_W'(ncols));
        fill_region(nrows, ncols);
        target = cmd_queue.size() + n_items;
        while (cmd_queue.size() < target) begin
            case ($urandom_range(9))
                0, 1: push_weight($urandom_range(mvm_pkg::MAX_ROWS - 1),
                                  $urandom_range(mvm_pkg::MAX_COLS - 1), pick_value());
                2: push_vector($urandom_range(1, ncols + 3), 1'b0, '0);
                default: push_vector(ncols, 1'b0, '0);
            endcase
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: too short a vector, then two past the buffer size
        push_vector(1, 1'b0, '0);
        push_vector(mvm_pkg::MAX_COLS + 2, 1'b0, '0);
        wait_idle();

        // small matrix: saturate high, then low
        write_reg(mvm_pkg::CFG_ROW_COUNT, mvm_pkg::CCNT_W'(2));
        write_reg(mvm_pkg::CFG_COL_COUNT, mvm_pkg::CCNT_W'(3));
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 3; c++) push_weight(r, c, 16'sh8000);
        push_vector(3, 1'b1, 16'sh8000);
        push_vector(3, 1'b1, 16'sh7FFF);
        push_vector(3, 1'b0, '0);
        wait_idle();

        random_phase(1, 1, 20);
        random_phase(mvm_pkg::MAX_ROWS, 2, 20);

        // row count out of range, column count that can never match
        write_reg(mvm_pkg::CFG_ROW_COUNT, 7'd0);
        write_reg(mvm_pkg::CFG_COL_COUNT, 7'd1);
        push_vector(1, 1'b0, '0);
        wait_idle();
        write_reg(mvm_pkg::CFG_ROW_COUNT, 7'd63);
        push_vector(1, 1'b0, '0);
        wait_idle();
        write_reg(mvm_pkg::CFG_COL_COUNT, 7'd0);
        push_vector(1, 1'b0, '0);
        wait_idle();
        write_reg(mvm_pkg::CFG_COL_COUNT, 7'd127);
        push_vector(2, 1'b0, '0);
        wait_idle();

        random_phase($urandom_range(2, 6), $urandom_range(2, 8), 40);

        if (expected_sums.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
